// ===== rtl/cilf_pkg.sv =====
// ----------------------------------------------------------------------------
// cilf_pkg
// Shared types, constants and helpers for the case-insensitive line filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cilf_pkg;

	// default sizes
	localparam int unsigned PATTERN_MAX_DEF  = 16;
	localparam int unsigned CHUNK_BUFFER_DEF = 2048;

	// fixed field widths
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned PAT_CHARS  = 16;
	localparam int unsigned PIDX_W     = $clog2(PAT_CHARS);
	localparam int unsigned LEN_W      = 5;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned LENGTH_W   = 11;

	localparam logic [LENGTH_W-1:0] LENGTH_SAT = 11'd2047;

	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t CHAR_NUL     = 8'h00;
	localparam char_t CHAR_NEWLINE = 8'h0A;
	localparam char_t CHAR_LOWER_A = 8'h61;
	localparam char_t CHAR_LOWER_Z = 8'h7A;
	localparam char_t CASE_OFFSET  = 8'h20;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd2;

	// configuration as seen by the scanner
	typedef struct packed {
		logic [LEN_W-1:0]            len;
		logic [PAT_CHARS*CHAR_W-1:0] pattern;
	} cfg_t;

	// per-byte verdict from the scanner
	typedef struct packed {
		logic                ends;
		logic                matched;
		logic [LENGTH_W-1:0] length;
		logic                final_chunk;
	} verdict_t;

	// ascii upper-case fold
	function automatic char_t fold_case(input char_t c);
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			return c - CASE_OFFSET;
		end
		return c;
	endfunction

	// pattern character by index, zero beyond the registers
	function automatic char_t pattern_char(input logic [PAT_CHARS*CHAR_W-1:0] pat,
			input logic [LEN_W-1:0] idx);
		if (idx >= LEN_W'(PAT_CHARS)) begin
			return CHAR_NUL;
		end
		return pat[CHAR_W*idx[PIDX_W-1:0] +: CHAR_W];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cilf_if.sv =====
// ----------------------------------------------------------------------------
// cilf_if
// Valid/ready channels for text bytes in and chunk verdicts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cilf_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface cilf_verdict_if;
	logic        valid;
	logic        ready;
	logic        chunk_matched;
	logic [10:0] chunk_length;
	logic        final_chunk;

	modport source (output valid, output chunk_matched, output chunk_length,
		output final_chunk, input ready);
	modport sink   (input valid, input chunk_matched, input chunk_length,
		input final_chunk, output ready);
endinterface

`default_nettype wire

// ===== rtl/cilf_cfg.sv =====
// ----------------------------------------------------------------------------
// cilf_cfg
// Pattern length and pattern character registers behind a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module cilf_cfg
	import cilf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	logic [LEN_W-1:0]      len_q;
	logic [CFG_DATA_W-1:0] low_q;
	logic [CFG_DATA_W-1:0] high_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			low_q  <= '0;
			high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PATTERN_LEN:  len_q  <= cfg_wdata[LEN_W-1:0];
				CFG_PATTERN_LOW:  low_q  <= cfg_wdata;
				CFG_PATTERN_HIGH: high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.len     = len_q;
	assign cfg.pattern = {high_q, low_q};

endmodule

`default_nettype wire

// ===== rtl/cilf_scan.sv =====
// ----------------------------------------------------------------------------
// cilf_scan
// Chunk state and window compare: one byte per step, verdict when a chunk ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cilf_scan
	import cilf_pkg::*;
#(
	parameter int unsigned PATTERN_MAX  = PATTERN_MAX_DEF,
	parameter int unsigned CHUNK_BUFFER = CHUNK_BUFFER_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire char_t text_byte,
	input  wire logic  end_of_text,
	input  wire cfg_t  cfg,
	output verdict_t   verdict
);

	localparam int unsigned CNT_W     = $clog2(CHUNK_BUFFER);
	localparam int unsigned CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int unsigned OUT_W     = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;
	localparam int unsigned PMAX_CLIP = (PATTERN_MAX > 31) ? 31 : PATTERN_MAX;

	char_t            recent_q [PATTERN_MAX];
	logic [CNT_W-1:0] chunk_q;
	logic [CNT_W-1:0] valid_q;
	logic             nul_q;
	logic             found_q;

	char_t            window [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hit;
	logic [LEN_W-1:0] act_len;
	logic [CNT_W-1:0] chunk_inc;
	logic [CNT_W-1:0] valid_next;
	logic             take;
	logic             match;
	logic             found_next;
	logic             ends;

	// effective pattern length
	assign act_len = (cfg.len > LEN_W'(PMAX_CLIP)) ? LEN_W'(PMAX_CLIP) : cfg.len;

	// counts and nul handling
	assign take       = !nul_q && (text_byte != CHAR_NUL);
	assign chunk_inc  = chunk_q + CNT_W'(1);
	assign valid_next = take ? valid_q + CNT_W'(1) : valid_q;

	// shifted window and per-position compare
	assign window[0] = fold_case(text_byte);
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pos
		if (k > 0) begin : g_shift
			assign window[k] = recent_q[k-1];
		end
		if (k >= 2**LEN_W) begin : g_unused
			assign hit[k] = 1'b1;
		end else begin : g_cmp
			logic  in_use;
			char_t pc;
			assign in_use = act_len > LEN_W'(k);
			assign pc     = pattern_char(cfg.pattern, act_len - LEN_W'(k + 1));
			assign hit[k] = !in_use || ((pc != CHAR_NUL) && (fold_case(pc) == window[k]));
		end
	end

	assign match      = (&hit) && (CMP_W'(valid_next) >= CMP_W'(act_len));
	assign found_next = found_q || (take && match);
	assign ends       = (text_byte == CHAR_NEWLINE) || end_of_text
		|| (chunk_inc == CNT_W'(CHUNK_BUFFER - 1));

	// verdict for the byte under way
	assign verdict.ends        = ends;
	assign verdict.matched     = (valid_next != '0) && ((act_len == '0) || found_next);
	assign verdict.length      = (OUT_W'(valid_next) > OUT_W'(LENGTH_SAT))
		? LENGTH_SAT : LENGTH_W'(valid_next);
	assign verdict.final_chunk = end_of_text;

	// chunk state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				recent_q[i] <= CHAR_NUL;
			end
			chunk_q <= '0;
			valid_q <= '0;
			nul_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (step) begin
			if (ends) begin
				for (int i = 0; i < PATTERN_MAX; i++) begin
					recent_q[i] <= CHAR_NUL;
				end
				chunk_q <= '0;
				valid_q <= '0;
				nul_q   <= 1'b0;
				found_q <= 1'b0;
			end else begin
				if (take) begin
					for (int i = 0; i < PATTERN_MAX; i++) begin
						recent_q[i] <= window[i];
					end
				end
				chunk_q <= chunk_inc;
				valid_q <= valid_next;
				nul_q   <= nul_q || (text_byte == CHAR_NUL);
				found_q <= found_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/case_insensitive_line_filter_top.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_line_filter_top
// Line-oriented case-insensitive pattern search over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   text_in carries one text byte per item plus an end-of-text mark. The
//   stream is cut into chunks that end after a newline, after
//   CHUNK_BUFFER-1 bytes or at the marked last byte. verdict_out carries
//   one item per chunk: match flag, length up to the first NUL, and
//   whether the chunk was the last one of the text.
//   The pattern is set through cfg_we/cfg_index/cfg_wdata while idle.
//   One byte is taken every cycle unless a chunk-ending byte waits. A
//   byte sits in the input register, where the window compare and
//   counters run; the verdict of a chunk-ending byte is loaded from there
//   into the output register, which drives verdict_out.valid.
//   When the receiver stalls, the verdict holds in the output register and
//   bytes that end no chunk keep flowing; a chunk-ending byte waits in the
//   input register until the output register frees, which holds
//   text_in.ready low.
//   Reset clears the pattern registers, chunk state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module case_insensitive_line_filter_top
	import cilf_pkg::*;
#(
	parameter int unsigned PATTERN_MAX  = PATTERN_MAX_DEF,
	parameter int unsigned CHUNK_BUFFER = CHUNK_BUFFER_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	cilf_text_if.sink                  text_in,
	cilf_verdict_if.source             verdict_out
);

	cfg_t     cfg;
	verdict_t verdict;

	logic  valid_s1;
	char_t byte_s1;
	logic  eot_s1;
	logic  out_valid_q;
	logic  out_matched_q;
	logic [LENGTH_W-1:0] out_length_q;
	logic  out_final_q;

	logic out_free;
	logic go_s1;
	logic accept;

	// handshake
	assign out_free       = !out_valid_q || verdict_out.ready;
	assign go_s1          = valid_s1 && (!verdict.ends || out_free);
	assign text_in.ready  = !valid_s1 || go_s1;
	assign accept         = text_in.valid && text_in.ready;

	cilf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cilf_scan #(
		.PATTERN_MAX  (PATTERN_MAX),
		.CHUNK_BUFFER (CHUNK_BUFFER)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (go_s1),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.cfg         (cfg),
		.verdict     (verdict)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_in.text_byte;
			eot_s1  <= text_in.end_of_text;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && verdict.ends) begin
			out_valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && verdict.ends) begin
			out_matched_q <= verdict.matched;
			out_length_q  <= verdict.length;
			out_final_q   <= verdict.final_chunk;
		end
	end

	assign verdict_out.valid         = out_valid_q;
	assign verdict_out.chunk_matched = out_matched_q;
	assign verdict_out.chunk_length  = out_length_q;
	assign verdict_out.final_chunk   = out_final_q;

endmodule

`default_nettype wire

// ===== rtl/cilf_checker.sv =====
// ----------------------------------------------------------------------------
// cilf_checker
// Port-level checks on the line filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cilf_checker
	import cilf_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [CHAR_W-1:0]   in_byte,
	input wire logic                in_eot,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic                out_matched,
	input wire logic [LENGTH_W-1:0] out_length,
	input wire logic                out_final
);

	// stalled verdict holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_matched)
			&& $stable(out_length) && $stable(out_final))
		else $error("stalled verdict changed");

	// a match needs a nonempty chunk
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_matched || (out_length != '0))
		else $error("match reported on empty chunk");

	// newline byte gives a verdict if the receiver is ready while it sits in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_byte == CHAR_NEWLINE) ##1 out_ready |=> out_valid)
		else $error("newline produced no verdict");

	// last byte gives a final verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_eot) ##1 out_ready |=> out_valid && out_final)
		else $error("end of text produced no final verdict");

endmodule

bind case_insensitive_line_filter_top cilf_checker u_cilf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (text_in.valid),
	.in_ready    (text_in.ready),
	.in_byte     (text_in.text_byte),
	.in_eot      (text_in.end_of_text),
	.out_valid   (verdict_out.valid),
	.out_ready   (verdict_out.ready),
	.out_matched (verdict_out.chunk_matched),
	.out_length  (verdict_out.chunk_length),
	.out_final   (verdict_out.final_chunk)
);

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives text bytes through the case-insensitive line filter under several
// patterns, predicts one verdict per chunk in a scoreboard and compares
// every verdict field against it, with random idling on both channels.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cilf_pkg::*;

	localparam int LATENCY     = 2;
	localparam int DRAIN       = LATENCY + 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT    = 36;
	localparam int CHUNK_LIMIT = CHUNK_BUFFER_DEF - 1;
	localparam int REPORT_MAX  = 10;

	localparam char_t CHAR_UPPER_A  = 8'h41;
	localparam char_t CHAR_UPPER_Z  = 8'h5A;
	localparam char_t CHAR_AT       = 8'h40;
	localparam char_t CHAR_GRAVE    = 8'h60;
	localparam char_t CHAR_LBRACKET = 8'h5B;
	localparam char_t CHAR_LBRACE   = 8'h7B;

	typedef enum {PAT_LETTERS, PAT_SYMBOLS, PAT_ANY, PAT_HOLE} pattern_style_t;

	typedef struct {
		char_t text_byte;
		bit    last;
	} text_item_t;

	typedef struct {
		bit                matched;
		bit [LENGTH_W-1:0] length;
		bit                final_chunk;
	} chunk_verdict_t;

	// chunk predictor plus store of verdicts still to come
	class chunk_scoreboard;
		bit [LEN_W-1:0]        pat_len;
		bit [2*CFG_DATA_W-1:0] pat_bits;
		char_t                 folded [PATTERN_MAX_DEF];
		int                    taken;
		int                    kept;
		bit                    nul_hit;
		bit                    found;
		chunk_verdict_t        awaited [$];
		int                    errors;

		function char_t upcase(input char_t c);
			return (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) ? (c ^ CASE_OFFSET) : c;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PATTERN_LEN:  pat_len = data[LEN_W-1:0];
				CFG_PATTERN_LOW:  pat_bits[CFG_DATA_W-1:0] = data;
				CFG_PATTERN_HIGH: pat_bits[2*CFG_DATA_W-1:CFG_DATA_W] = data;
				default: ;
			endcase
		endfunction

		// newest folded bytes against the pattern, last pattern char newest
		function bit window_hits(input int act);
			char_t p;
			if (kept < act)
				return 1'b0;
			for (int k = 0; k < act; k++) begin
				p = pat_bits[CHAR_W*(act-1-k) +: CHAR_W];
				if (p == CHAR_NUL || upcase(p) != folded[k])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_byte(input char_t b, input bit last);
			int             act;
			bit             ends;
			chunk_verdict_t v;
			act = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
			taken++;
			// bytes from the first nul on are dead for matching and length
			if (!nul_hit) begin
				if (b == CHAR_NUL) begin
					nul_hit = 1'b1;
				end else begin
					for (int k = PATTERN_MAX_DEF - 1; k > 0; k--)
						folded[k] = folded[k-1];
					folded[0] = upcase(b);
					kept++;
					if (window_hits(act))
						found = 1'b1;
				end
			end
			ends = (b == CHAR_NEWLINE) || (taken >= CHUNK_LIMIT) || last;
			if (ends) begin
				v.matched     = (kept > 0) && (act == 0 || found);
				v.length      = (kept > int'(LENGTH_SAT)) ? LENGTH_SAT : LENGTH_W'(kept);
				v.final_chunk = last;
				awaited.push_back(v);
				foreach (folded[k])
					folded[k] = CHAR_NUL;
				taken   = 0;
				kept    = 0;
				nul_hit = 1'b0;
				found   = 1'b0;
			end
		endfunction

		function void check_verdict(input logic m, input logic [LENGTH_W-1:0] l,
				input logic f);
			chunk_verdict_t v;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: verdict with no chunk pending: %s%b length=%0d final=%b",
						$time, "matched=", m, l, f);
				return;
			end
			v = awaited.pop_front();
			if (m !== v.matched || l !== v.length || f !== v.final_chunk) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display({"%0t: verdict mismatch: expected matched=%b length=%0d final=%b,",
						" got matched=%b length=%0d final=%b"},
						$time, v.matched, v.length, v.final_chunk, m, l, f);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cilf_text_if    text_ch ();
	cilf_verdict_if verdict_ch ();

	chunk_scoreboard board = new();
	text_item_t      script [$];
	char_t           pat_chars [PATTERN_MAX_DEF];
	int              pat_active;
	bit              steady;
	bit              hold_request;

	case_insensitive_line_filter_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.text_in     (text_ch),
		.verdict_out (verdict_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// text generation helpers
	function automatic char_t vary_case(input char_t c);
		if ((c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]} || c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
				&& $urandom_range(1) == 1)
			return c ^ CASE_OFFSET;
		return c;
	endfunction

	function automatic char_t any_letter();
		if (pat_active > 0 && $urandom_range(1) == 1)
			return vary_case(pat_chars[$urandom_range(pat_active - 1)]);
		return vary_case(char_t'(CHAR_UPPER_A + $urandom_range(25)));
	endfunction

	function automatic char_t plain_byte();
		char_t c;
		do c = char_t'($urandom_range(255)); while (c == CHAR_NUL || c == CHAR_NEWLINE);
		return c;
	endfunction

	function automatic void push_item(input char_t c, input bit last);
		text_item_t t;
		t.text_byte = c;
		t.last      = last;
		script.push_back(t);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_item(char_t'(s[i]), 1'b0);
	endfunction

	// one pattern occurrence in random case, or one with a char spoiled
	function automatic void plant(input bit whole);
		int    spoil;
		char_t c;
		if (pat_active == 0) begin
			push_item(any_letter(), 1'b0);
			return;
		end
		spoil = whole ? -1 : $urandom_range(pat_active - 1);
		for (int i = 0; i < pat_active; i++) begin
			c = vary_case(pat_chars[i]);
			if (i == spoil)
				c = c ^ (($urandom_range(1) == 1) ? CASE_OFFSET : char_t'($urandom_range(255, 1)));
			push_item(c, 1'b0);
		end
	endfunction

	// short lines, mostly letters and pattern pieces, some noise
	function automatic void make_text(input int n);
		int roll;
		while (script.size() < n) begin
			roll = $urandom_range(99);
			if (roll < 30)
				plant(1'b1);
			else if (roll < 40)
				plant(1'b0);
			else if (roll < 72)
				push_item(any_letter(), 1'b0);
			else if (roll < 85)
				push_item(char_t'($urandom_range(255)), 1'b0);
			else if (roll < 88)
				push_item(CHAR_NUL, 1'b0);
			else if (roll < 97)
				push_item(CHAR_NEWLINE, 1'b0);
			else
				push_item(char_t'($urandom_range(255)), 1'b1);
		end
		script[script.size() - 1].last = 1'b1;
	endfunction

	// one chunk cut by the byte limit: match near its end, then a nul whose
	// trailing bytes still count toward the limit, then a short tail chunk
	function automatic void make_long();
		repeat (CHUNK_LIMIT - 40) push_item(plain_byte(), 1'b0);
		plant(1'b1);
		push_item(CHAR_NUL, 1'b0);
		repeat (60) push_item(plain_byte(), 1'b0);
		push_item(CHAR_NEWLINE, 1'b1);
	endfunction

	function automatic char_t style_char(input pattern_style_t style);
		case (style)
			PAT_SYMBOLS: begin
				case ($urandom_range(5))
					0: return CHAR_AT;
					1: return CHAR_LBRACKET;
					2: return CHAR_GRAVE;
					3: return CHAR_LBRACE;
					4: return char_t'(8'h80 + $urandom_range(127));
					default: return vary_case(char_t'(CHAR_UPPER_A + $urandom_range(25)));
				endcase
			end
			PAT_ANY: return char_t'($urandom_range(255, 1));
			default: return vary_case(char_t'(CHAR_UPPER_A + $urandom_range(25)));
		endcase
	endfunction

	// configuration writes, all three registers back to back
	task automatic write_regs(input logic [LEN_W-1:0] len, input logic [CFG_DATA_W-1:0] low,
			input logic [CFG_DATA_W-1:0] high);
		logic [CFG_DATA_W-1:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = len;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PATTERN_LEN;
		cfg_wdata <= len_word;
		board.write_reg(CFG_PATTERN_LEN, len_word);
		@(posedge clk);
		cfg_index <= CFG_PATTERN_LOW;
		cfg_wdata <= low;
		board.write_reg(CFG_PATTERN_LOW, low);
		@(posedge clk);
		cfg_index <= CFG_PATTERN_HIGH;
		cfg_wdata <= high;
		board.write_reg(CFG_PATTERN_HIGH, high);
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int i = 0; i < PATTERN_MAX_DEF; i++)
			pat_chars[i] = (i < 8) ? low[CHAR_W*i +: CHAR_W] : high[CHAR_W*(i-8) +: CHAR_W];
		pat_active = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(len);
	endtask

	// text sender
	task automatic send_script();
		foreach (script[i]) begin
			while (!steady && $urandom_range(99) < IDLE_PCT) begin
				text_ch.valid <= 1'b0;
				@(posedge clk);
			end
			text_ch.valid       <= 1'b1;
			text_ch.text_byte   <= script[i].text_byte;
			text_ch.end_of_text <= script[i].last;
			do @(posedge clk); while (!text_ch.ready);
			board.note_byte(script[i].text_byte, script[i].last);
		end
		text_ch.valid <= 1'b0;
		script.delete();
	endtask

	// wait for all verdicts, then for the pipeline to empty
	task automatic settle();
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic run_phase(input int len, input pattern_style_t style, input int n,
			input bit calm, input bit squeeze, input bit wide);
		logic [2*CFG_DATA_W-1:0] pat_word;
		int                      act;
		int                      hole;
		act = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len;
		for (int i = 0; i < PATTERN_MAX_DEF; i++)
			pat_word[CHAR_W*i +: CHAR_W] = style_char(style);
		if (style == PAT_HOLE && act > 0) begin
			hole = $urandom_range(act - 1);
			pat_word[CHAR_W*hole +: CHAR_W] = CHAR_NUL;
		end
		settle();
		write_regs(LEN_W'(len), pat_word[CFG_DATA_W-1:0], pat_word[2*CFG_DATA_W-1:CFG_DATA_W]);
		if (wide)
			make_long();
		else
			make_text(n);
		steady       = calm;
		hold_request = squeeze;
		send_script();
		steady = 1'b0;
	endtask

	// verdict receiver
	initial begin : verdict_side
		int hold_left;
		hold_left = 0;
		verdict_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (verdict_ch.valid && verdict_ch.ready)
				board.check_verdict(verdict_ch.chunk_matched, verdict_ch.chunk_length,
					verdict_ch.final_chunk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				verdict_ch.ready <= 1'b0;
			end else begin
				verdict_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// watchdog on cycles without any handshake
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((text_ch.valid && text_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: errors");
		$finish;
	end

	// main sequence
	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= CFG_PATTERN_LEN;
		cfg_wdata           <= '0;
		text_ch.valid       <= 1'b0;
		text_ch.text_byte   <= CHAR_NUL;
		text_ch.end_of_text <= 1'b0;
		steady              = 1'b0;
		hold_request        = 1'b0;
		pat_active          = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset pattern is empty: nul-first chunk, bare newline, nul mid chunk,
		// high bytes, newline on the last byte
		push_item(CHAR_NUL, 1'b0);
		push_item(CHAR_NEWLINE, 1'b0);
		push_item(CHAR_NEWLINE, 1'b0);
		push_text("a");
		push_item(8'hFF, 1'b0);
		push_item(CHAR_NUL, 1'b0);
		push_text("b\n");
		push_item(8'h80, 1'b1);
		push_item(CHAR_NEWLINE, 1'b1);
		send_script();

		// pattern around the case fold boundaries
		settle();
		write_regs(LEN_W'(4), {$urandom, CHAR_LBRACKET, CHAR_GRAVE, 8'h62, CHAR_UPPER_A},
			{$urandom, $urandom});
		push_text("xaB");
		push_item(CHAR_GRAVE, 1'b0);
		push_text("[\n");
		push_text("AB@{\n");
		push_text("ab");
		push_item(CHAR_GRAVE, 1'b0);
		push_item(CHAR_LBRACKET, 1'b1);
		send_script();

		// random phases
		run_phase(0, PAT_ANY, 45, 1'b0, 1'b0, 1'b0);
		run_phase(1, PAT_LETTERS, 45, 1'b0, 1'b0, 1'b0);
		run_phase($urandom_range(5, 2), PAT_LETTERS, 45, 1'b0, 1'b1, 1'b0);
		run_phase(3, PAT_SYMBOLS, 45, 1'b0, 1'b0, 1'b0);
		run_phase(6, PAT_HOLE, 45, 1'b0, 1'b0, 1'b0);
		run_phase(8, PAT_LETTERS, 80, 1'b1, 1'b0, 1'b0);
		run_phase(9, PAT_ANY, 45, 1'b0, 1'b0, 1'b0);
		run_phase(PATTERN_MAX_DEF, PAT_LETTERS, 45, 1'b0, 1'b0, 1'b0);
		run_phase(PATTERN_MAX_DEF, PAT_SYMBOLS, 45, 1'b0, 1'b0, 1'b0);
		run_phase($urandom_range(30, 17), PAT_LETTERS, 45, 1'b0, 1'b0, 1'b0);
		run_phase(31, PAT_ANY, 45, 1'b0, 1'b0, 1'b0);
		run_phase($urandom_range(15, 1), PAT_LETTERS, 45, 1'b0, 1'b0, 1'b0);
		run_phase($urandom_range(15, 1), PAT_HOLE, 45, 1'b0, 1'b0, 1'b0);
		run_phase(4, PAT_LETTERS, 0, 1'b0, 1'b0, 1'b1);

		settle();
		if (board.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cilf_pkg.sv
rtl/cilf_if.sv
rtl/cilf_cfg.sv
rtl/cilf_scan.sv
rtl/case_insensitive_line_filter_top.sv
rtl/cilf_checker.sv
test/testbench.sv
